FILE: rtl/lsle_pkg.sv
// shared types, codes and control store of the led strip line encoder
`timescale 1ns / 1ps
package lsle_pkg;

  // one pixel request
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       final_pixel;
  } pix_t;

  // one line symbol
  typedef struct packed {
    logic [8:0]  high_cycles;
    logic [15:0] low_cycles;
    logic        data_bit;
    logic        latch_gap;
    logic        end_of_run;
  } sym_t;

  // configuration registers
  typedef struct packed {
    logic [2:0]  channels_per_pixel;
    logic [7:0]  colour_order;
    logic [15:0] strip_len;
    logic [11:0] reset_gap_bits;
    logic [8:0]  bit_period;
    logic [8:0]  zero_high_time;
    logic [8:0]  one_high_time;
  } cfg_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_CHANNELS   = 3'd0;
  localparam logic [2:0] REG_ORDER      = 3'd1;
  localparam logic [2:0] REG_CHAIN      = 3'd2;
  localparam logic [2:0] REG_GAP_BITS   = 3'd3;
  localparam logic [2:0] REG_PERIOD     = 3'd4;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd5;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd6;

  localparam logic [1:0] SLOT_RED   = 2'd0;
  localparam logic [1:0] SLOT_GREEN = 2'd1;
  localparam logic [1:0] SLOT_BLUE  = 2'd2;

  localparam logic [8:0]  HIGH_CAP = 9'd510;
  localparam logic [15:0] GAP_CAP  = 16'hFFFF;

  // sequencer step addresses
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CHAN   = 3'd1,
    ST_DATA   = 3'd2,
    ST_NEXT   = 3'd3,
    ST_FINCHK = 3'd4,
    ST_TRLCHK = 3'd5,
    ST_TRAIL  = 3'd6,
    ST_GAP    = 3'd7
  } step_t;

  typedef enum logic [1:0] {
    SYM_NONE = 2'd0,
    SYM_DATA = 2'd1,
    SYM_ZERO = 2'd2,
    SYM_GAP  = 2'd3
  } sym_kind_t;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_NO_INPUT  = 3'd1,
    COND_CHAN_END  = 3'd2,
    COND_BIT_MORE  = 3'd3,
    COND_NOT_FINAL = 3'd4,
    COND_TRL_NONE  = 3'd5,
    COND_TRL_MORE  = 3'd6
  } cond_t;

  // one control word
  typedef struct packed {
    logic      take_in;
    sym_kind_t sym;
    logic      ld_byte;
    logic      next_chan;
    logic      clr_trl;
    cond_t     cond;
    step_t     target;
  } ctrl_t;

  // control word plus its strobes, sequencer to datapath
  typedef struct packed {
    logic  fire;
    logic  accept;
    ctrl_t cw;
  } uop_t;

  // datapath status, datapath to sequencer
  typedef struct packed {
    logic out_free;
    logic chan_end;
    logic bit_more;
    logic not_final;
    logic trl_none;
    logic trl_more;
  } stat_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t cw;
    cw = '{take_in: 1'b0, sym: SYM_NONE, ld_byte: 1'b0, next_chan: 1'b0,
           clr_trl: 1'b0, cond: COND_ALWAYS, target: ST_IDLE};
    unique case (s)
      ST_IDLE: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_NO_INPUT;
        cw.target  = ST_IDLE;
      end
      ST_CHAN: begin
        cw.ld_byte = 1'b1;
        cw.cond    = COND_CHAN_END;
        cw.target  = ST_FINCHK;
      end
      ST_DATA: begin
        cw.sym    = SYM_DATA;
        cw.cond   = COND_BIT_MORE;
        cw.target = ST_DATA;
      end
      ST_NEXT: begin
        cw.next_chan = 1'b1;
        cw.cond      = COND_ALWAYS;
        cw.target    = ST_CHAN;
      end
      ST_FINCHK: begin
        cw.cond   = COND_NOT_FINAL;
        cw.target = ST_IDLE;
      end
      ST_TRLCHK: begin
        cw.clr_trl = 1'b1;
        cw.cond    = COND_TRL_NONE;
        cw.target  = ST_GAP;
      end
      ST_TRAIL: begin
        cw.sym    = SYM_ZERO;
        cw.cond   = COND_TRL_MORE;
        cw.target = ST_TRAIL;
      end
      ST_GAP: begin
        cw.sym    = SYM_GAP;
        cw.cond   = COND_ALWAYS;
        cw.target = ST_IDLE;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/lsle_cfg_regs.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps
module lsle_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsle_pkg::ADDR_W-1:0] paddr,
  input  logic [lsle_pkg::DATA_W-1:0] pwdata,
  output logic [lsle_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output lsle_pkg::cfg_t              cfg
);

  lsle_pkg::cfg_t cfg_r;
  lsle_pkg::cfg_t cfg_nxt;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[lsle_pkg::ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        lsle_pkg::REG_CHANNELS:  cfg_nxt.channels_per_pixel = pwdata[2:0];
        lsle_pkg::REG_ORDER:     cfg_nxt.colour_order       = pwdata[7:0];
        lsle_pkg::REG_CHAIN:     cfg_nxt.strip_len          = pwdata[15:0];
        lsle_pkg::REG_GAP_BITS:  cfg_nxt.reset_gap_bits     = pwdata[11:0];
        lsle_pkg::REG_PERIOD:    cfg_nxt.bit_period         = pwdata[8:0];
        lsle_pkg::REG_ZERO_HIGH: cfg_nxt.zero_high_time     = pwdata[8:0];
        lsle_pkg::REG_ONE_HIGH:  cfg_nxt.one_high_time      = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channels_per_pixel <= 3'd3;
      cfg_r.colour_order       <= 8'd225;
      cfg_r.strip_len          <= 16'd8;
      cfg_r.reset_gap_bits     <= 12'd40;
      cfg_r.bit_period         <= 9'd20;
      cfg_r.zero_high_time     <= 9'd5;
      cfg_r.one_high_time      <= 9'd15;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      lsle_pkg::REG_CHANNELS:  prdata = 32'(cfg_r.channels_per_pixel);
      lsle_pkg::REG_ORDER:     prdata = 32'(cfg_r.colour_order);
      lsle_pkg::REG_CHAIN:     prdata = 32'(cfg_r.strip_len);
      lsle_pkg::REG_GAP_BITS:  prdata = 32'(cfg_r.reset_gap_bits);
      lsle_pkg::REG_PERIOD:    prdata = 32'(cfg_r.bit_period);
      lsle_pkg::REG_ZERO_HIGH: prdata = 32'(cfg_r.zero_high_time);
      lsle_pkg::REG_ONE_HIGH:  prdata = 32'(cfg_r.one_high_time);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: rtl/lsle_useq.sv
// microcode sequencer: step counter, control store lookup and jumps
`timescale 1ns / 1ps
module lsle_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lsle_pkg::stat_t     stat,
  output lsle_pkg::uop_t      uop,
  output lsle_pkg::step_t     step,
  output logic                in_stall
);

  lsle_pkg::step_t step_r;
  lsle_pkg::step_t step_nxt;
  lsle_pkg::ctrl_t cw;
  logic            fire;
  logic            jump;

  assign cw = lsle_pkg::ucode(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lsle_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    // a symbol-producing step waits for room in the output register
    fire = (cw.sym == lsle_pkg::SYM_NONE) || stat.out_free;
    unique case (cw.cond)
      lsle_pkg::COND_ALWAYS:    jump = 1'b1;
      lsle_pkg::COND_NO_INPUT:  jump = !in_valid;
      lsle_pkg::COND_CHAN_END:  jump = stat.chan_end;
      lsle_pkg::COND_BIT_MORE:  jump = stat.bit_more;
      lsle_pkg::COND_NOT_FINAL: jump = stat.not_final;
      lsle_pkg::COND_TRL_NONE:  jump = stat.trl_none;
      lsle_pkg::COND_TRL_MORE:  jump = stat.trl_more;
      default:                  jump = 1'b1;
    endcase
    if (!fire) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = lsle_pkg::step_t'(step_r + 3'd1);
    end
    uop.fire   = fire;
    uop.accept = cw.take_in & in_valid;
    uop.cw     = cw;
    in_stall   = !cw.take_in;
    step       = step_r;
  end

endmodule

FILE: rtl/lsle_datapath.sv
// pixel, bit and trailer datapath with symbol timing and output register
`timescale 1ns / 1ps
module lsle_datapath #(
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned TRAILER_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lsle_pkg::cfg_t  cfg,
  input  lsle_pkg::pix_t  in_data,
  input  lsle_pkg::uop_t  uop,
  input  logic            out_stall,
  output lsle_pkg::stat_t stat,
  output logic            out_valid,
  output lsle_pkg::sym_t  out_data
);

  localparam int unsigned TRL_W = $clog2(TRAILER_BITS + 2);
  localparam logic [TRL_W-1:0] TRL_LAST = TRL_W'(TRAILER_BITS - 1);

  lsle_pkg::pix_t  pix_r;
  logic            in_range_r;
  logic [7:0]      byte_r;
  logic [2:0]      bit_cnt_r;
  logic [2:0]      chan_cnt_r;
  logic [TRL_W-1:0] trl_cnt_r;
  logic [15:0]     pixels_sent_r;
  logic [15:0]     gap_r;
  logic            out_valid_r;
  lsle_pkg::sym_t  out_r;
  lsle_pkg::sym_t  sym;

  logic [20:0]     gap_prod;
  logic [2:0]      n_eff;
  logic            last_chan;
  logic [1:0]      slot;
  logic [7:0]      sel_byte;
  logic            bit_val;
  logic [8:0]      high_raw;
  logic [8:0]      high;
  logic [15:0]     low;
  logic            emit;

  assign n_eff = (cfg.channels_per_pixel > 3'(MAX_CHANNELS)) ?
                 3'(MAX_CHANNELS) : cfg.channels_per_pixel;
  assign last_chan = 3'(chan_cnt_r + 3'd1) >= n_eff;
  assign slot = cfg.colour_order[{chan_cnt_r[1:0], 1'b0} +: 2];
  assign gap_prod = 21'(cfg.bit_period) * 21'(cfg.reset_gap_bits);

  always_comb begin
    case (slot)
      lsle_pkg::SLOT_RED:   sel_byte = pix_r.red;
      lsle_pkg::SLOT_GREEN: sel_byte = pix_r.green;
      lsle_pkg::SLOT_BLUE:  sel_byte = pix_r.blue;
      default:              sel_byte = 8'd0;
    endcase
  end

  // symbol timing
  always_comb begin
    bit_val  = (uop.cw.sym == lsle_pkg::SYM_DATA) ? byte_r[7] : 1'b0;
    high_raw = bit_val ? cfg.one_high_time : cfg.zero_high_time;
    high     = (high_raw > lsle_pkg::HIGH_CAP) ? lsle_pkg::HIGH_CAP : high_raw;
    low      = (cfg.bit_period > high) ? 16'(cfg.bit_period - high) : 16'd0;
    if (uop.cw.sym == lsle_pkg::SYM_GAP) begin
      sym.high_cycles = 9'd0;
      sym.low_cycles  = gap_r;
      sym.data_bit    = 1'b0;
      sym.latch_gap   = 1'b1;
      sym.end_of_run  = 1'b1;
    end else begin
      sym.high_cycles = high;
      sym.low_cycles  = low;
      sym.data_bit    = bit_val;
      sym.latch_gap   = 1'b0;
      sym.end_of_run  = (uop.cw.sym == lsle_pkg::SYM_DATA) && (bit_cnt_r == 3'd7) &&
                        last_chan && !pix_r.final_pixel;
    end
  end

  assign emit = uop.fire && (uop.cw.sym != lsle_pkg::SYM_NONE);

  always_comb begin
    stat.out_free  = !out_valid_r || !out_stall;
    stat.chan_end  = !in_range_r || (chan_cnt_r >= n_eff);
    stat.bit_more  = bit_cnt_r != 3'd7;
    stat.not_final = !pix_r.final_pixel;
    stat.trl_none  = TRAILER_BITS == 0;
    stat.trl_more  = trl_cnt_r != TRL_LAST;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_sent_r <= 16'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (uop.accept) begin
        if (in_data.final_pixel) begin
          pixels_sent_r <= 16'd0;
        end else if (pixels_sent_r < cfg.strip_len) begin
          pixels_sent_r <= 16'(pixels_sent_r + 16'd1);
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    gap_r <= (gap_prod > 21'(lsle_pkg::GAP_CAP)) ? lsle_pkg::GAP_CAP : gap_prod[15:0];
    if (uop.accept) begin
      pix_r      <= in_data;
      in_range_r <= pixels_sent_r < cfg.strip_len;
      chan_cnt_r <= 3'd0;
    end
    if (uop.fire && uop.cw.ld_byte) begin
      byte_r    <= sel_byte;
      bit_cnt_r <= 3'd0;
    end
    if (uop.fire && (uop.cw.sym == lsle_pkg::SYM_DATA)) begin
      byte_r    <= {byte_r[6:0], 1'b0};
      bit_cnt_r <= 3'(bit_cnt_r + 3'd1);
    end
    if (uop.fire && uop.cw.next_chan) begin
      chan_cnt_r <= 3'(chan_cnt_r + 3'd1);
    end
    if (uop.fire && uop.cw.clr_trl) begin
      trl_cnt_r <= '0;
    end
    if (uop.fire && (uop.cw.sym == lsle_pkg::SYM_ZERO)) begin
      trl_cnt_r <= TRL_W'(trl_cnt_r + 1'b1);
    end
    if (emit) begin
      out_r <= sym;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/led_strip_line_encoder.sv
// top level of the led strip line encoder
`timescale 1ns / 1ps
//
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    lsle_pkg::pix_t (red, green, blue, final_pixel)
// out_      output     out_valid / out_stall  lsle_pkg::sym_t (one line symbol)
// cfg       apb-style  psel/penable/pwrite    32-bit registers at byte address 4*index
//
// one pixel request at a time; a microcoded step counter walks the control store.
// per pixel: take it; per colour byte a load, 8 bit symbols and an advance; close the
// byte loop; for a final pixel a trailer clear, TRAILER_BITS zero symbols, the latch gap.
// the reset default (3 bytes, not final) gives 24 symbols, at most one a cycle
// out_stall holds the output register and freezes the step counter on symbol steps
// rst_n is synchronous; it clears the step counter, pixel count and output valid
module led_strip_line_encoder #(
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned TRAILER_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lsle_pkg::pix_t              in_data,
  // symbol results
  output logic                        out_valid,
  input  logic                        out_stall,
  output lsle_pkg::sym_t              out_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsle_pkg::ADDR_W-1:0] paddr,
  input  logic [lsle_pkg::DATA_W-1:0] pwdata,
  output logic [lsle_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  lsle_pkg::cfg_t  cfg;
  lsle_pkg::uop_t  uop;
  lsle_pkg::stat_t stat;
  lsle_pkg::step_t step;

  // register file
  lsle_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step counter and control store
  lsle_useq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .uop      (uop),
    .step     (step),
    .in_stall (in_stall)
  );

  // pixel holding, bit shifting, counters and symbol timing
  lsle_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .TRAILER_BITS (TRAILER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .uop       (uop),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a taken pixel keeps the input closed for at least the next cycle
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && (step == lsle_pkg::ST_CHAN))
    else $error("input still open after a pixel was taken");

  // the latch gap always ends a run and carries no high time
  a_gap_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.latch_gap |->
      out_data.end_of_run && (out_data.high_cycles == 9'd0) && !out_data.data_bit)
    else $error("malformed latch gap symbol");

  // high time is capped below the field maximum
  a_high_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.high_cycles <= lsle_pkg::HIGH_CAP)
    else $error("high time above cap");

  // a symbol step only fires into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    uop.fire && (uop.cw.sym != lsle_pkg::SYM_NONE) |-> !out_valid || !out_stall)
    else $error("symbol overwrote a stalled result");

endmodule
